/* sv/stl_pkg.sv */
// Shared types and constants for the SQL token lexer.
// Holds beat structs, token kind codes, scan modes and the keyword table.
// No dependencies.
package stl_pkg;

  // Defaults for top-level parameters
  localparam int MAX_STMT_BYTES_DEF = 4096;
  localparam int KEYWORD_CHARS_DEF  = 6;

  // Result queue sizing: one input beat pushes at most MAX_RESULTS entries
  localparam int MAX_RESULTS    = 3;
  localparam int RES_FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W     = $clog2(RES_FIFO_DEPTH);

  // Token kind codes
  localparam logic [5:0] KIND_END     = 6'd0;
  localparam logic [5:0] KIND_IDENT   = 6'd1;
  localparam logic [5:0] KIND_NUMBER  = 6'd2;
  localparam logic [5:0] KIND_STRING  = 6'd3;
  localparam logic [5:0] KIND_COMMA   = 6'd4;
  localparam logic [5:0] KIND_LPAREN  = 6'd5;
  localparam logic [5:0] KIND_RPAREN  = 6'd6;
  localparam logic [5:0] KIND_EQ      = 6'd7;
  localparam logic [5:0] KIND_NE      = 6'd8;
  localparam logic [5:0] KIND_LT      = 6'd9;
  localparam logic [5:0] KIND_LE      = 6'd10;
  localparam logic [5:0] KIND_GT      = 6'd11;
  localparam logic [5:0] KIND_GE      = 6'd12;
  localparam logic [5:0] KIND_PLUS    = 6'd13;
  localparam logic [5:0] KIND_MINUS   = 6'd14;
  localparam logic [5:0] KIND_STAR    = 6'd15;
  localparam logic [5:0] KIND_SLASH   = 6'd16;
  localparam int         KIND_KW_BASE = 17;

  // Keyword table: text right-aligned, first character in the top used byte
  localparam int KW_MAX = 6;
  localparam int NUM_KW = 19;

  localparam logic [8*KW_MAX-1:0] KW_TEXT [NUM_KW] = '{
    "SELECT", "FROM", "WHERE", "INNER", "JOIN", "ON", "GROUP", "BY",
    "HAVING", "ORDER", "ASC", "DESC", "LIMIT", "SUM", "COUNT", "AVG",
    "AS", "AND", "OR"
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd6, 3'd4, 3'd5, 3'd5, 3'd4, 3'd2, 3'd5, 3'd2,
    3'd6, 3'd5, 3'd3, 3'd4, 3'd5, 3'd3, 3'd5, 3'd3,
    3'd2, 3'd3, 3'd2
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_STR,
    MODE_LT,
    MODE_GT,
    MODE_BANG,
    MODE_ERR
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stmt_last;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [11:0] token_start;
    logic [12:0] token_len;
    logic        lex_error;
    logic        run_last;
  } res_t;

  // Results of one input beat, in order, each with its own valid bit
  typedef struct packed {
    logic [MAX_RESULTS-1:0]       valid;
    res_t [MAX_RESULTS-1:0]       slot;
  } res_push_t;

  // Map a word (left-aligned text, length 0 when too long) to its kind
  function automatic logic [5:0] kw_kind(input logic [8*KW_MAX-1:0] txt,
                                         input logic [2:0] len);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (len == KW_LEN[k] &&
          (txt >> (8 * (KW_MAX - int'(KW_LEN[k])))) == KW_TEXT[k]) begin
        kind = 6'(KIND_KW_BASE + k);
      end
    end
    return kind;
  endfunction

endpackage

/* sv/stl_scan.sv */
// Scan state machine of the SQL token lexer: classifies one byte a beat,
// keeps the pending token and emits up to three results. Uses stl_pkg.
module stl_scan
  import stl_pkg::*;
#(
  parameter int MAX_STMT_BYTES = MAX_STMT_BYTES_DEF,
  parameter int KEYWORD_CHARS  = KEYWORD_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_beat_t  beat,
  output res_push_t push
);

  localparam int LEN_W = $clog2(MAX_STMT_BYTES + 1);
  localparam int PW    = $clog2(MAX_STMT_BYTES);
  localparam int IW    = $clog2(KEYWORD_CHARS);

  mode_t             mode_r, mode_nxt, mode_mid;
  logic [PW-1:0]     start_r, start_nxt, start_mid;
  logic [LEN_W-1:0]  len_r, len_nxt, len_mid;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        word_buf_r [KEYWORD_CHARS];
  logic [7:0]        word_buf_nxt [KEYWORD_CHARS];

  logic [PW-1:0]         p;
  logic [7:0]            b;
  logic                  last, fresh;
  logic                  is_alpha, is_digit, is_word, is_space;
  logic [8*KW_MAX-1:0]   txt_old, txt_new;
  logic                  va, vb, vc, vd;
  res_t                  ra, rb, rc, rd;
  res_push_t             push_c;

  // Build one result with the fields widened or truncated to port widths
  function automatic res_t mk(input logic [5:0] kind, input logic [PW-1:0] start,
                              input logic [LEN_W-1:0] len, input logic err);
    res_t               r;
    logic [PW+11:0]     s_ext;
    logic [LEN_W+12:0]  l_ext;
    s_ext         = {12'b0, start};
    l_ext         = {13'b0, len};
    r.token_kind  = kind;
    r.token_start = s_ext[11:0];
    r.token_len   = l_ext[12:0];
    r.lex_error   = err;
    r.run_last    = 1'b0;
    return r;
  endfunction

  // Saturating increment of a length or position
  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    logic [LEN_W:0] s;
    s = {1'b0, v} + (LEN_W+1)'(1);
    if (s >= (LEN_W+1)'(MAX_STMT_BYTES)) begin
      return LEN_W'(MAX_STMT_BYTES);
    end
    return s[LEN_W-1:0];
  endfunction

  // Word length as seen by the keyword compare: zero when no keyword fits
  function automatic logic [2:0] kw_len(input logic [LEN_W-1:0] v);
    if (v <= LEN_W'(KW_MAX)) begin
      return v[2:0];
    end
    return 3'd0;
  endfunction

  // Hold scan state; advance only on a consumed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Keep the first bytes of the current word for the keyword compare
  always_ff @(posedge clk) begin
    if (fire) begin
      word_buf_r <= word_buf_nxt;
    end
  end

  // Next state and results for the beat at hand
  always_comb begin
    b    = beat.byte_in;
    last = beat.stmt_last;
    p    = (pos_r >= LEN_W'(MAX_STMT_BYTES)) ? PW'(MAX_STMT_BYTES - 1) : pos_r[PW-1:0];

    is_alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    is_digit = (b >= "0" && b <= "9");
    is_word  = is_alpha || is_digit || (b == "_");
    is_space = (b == " ") || (b >= 8'h09 && b <= 8'h0d);

    for (int i = 0; i < KW_MAX; i++) begin
      txt_old[8*(KW_MAX-1-i) +: 8] = word_buf_r[i];
    end

    mode_mid     = mode_r;
    start_mid    = start_r;
    len_mid      = len_r;
    word_buf_nxt = word_buf_r;
    fresh        = 1'b0;
    va = 1'b0; vb = 1'b0; vc = 1'b0; vd = 1'b0;
    ra = '0;   rb = '0;   rc = '0;   rd = '0;

    // Extend or close the pending token
    case (mode_r)
      MODE_WORD: begin
        if (is_word) begin
          if (len_r < LEN_W'(KEYWORD_CHARS)) begin
            word_buf_nxt[len_r[IW-1:0]] = b;
          end
          len_mid = sat_inc(len_r);
        end else begin
          va    = 1'b1;
          ra    = mk(kw_kind(txt_old, kw_len(len_r)), start_r, len_r, 1'b0);
          fresh = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_digit) begin
          len_mid = sat_inc(len_r);
        end else begin
          va    = 1'b1;
          ra    = mk(KIND_NUMBER, start_r, len_r, 1'b0);
          fresh = 1'b1;
        end
      end
      MODE_STR: begin
        len_mid = sat_inc(len_r);
        if (b == "'") begin
          va       = 1'b1;
          ra       = mk(KIND_STRING, start_r, len_mid, 1'b0);
          mode_mid = MODE_IDLE;
        end
      end
      MODE_LT, MODE_GT: begin
        va = 1'b1;
        if (b == "=") begin
          ra       = mk((mode_r == MODE_LT) ? KIND_LE : KIND_GE, start_r,
                        LEN_W'(2), 1'b0);
          mode_mid = MODE_IDLE;
        end else begin
          ra    = mk((mode_r == MODE_LT) ? KIND_LT : KIND_GT, start_r,
                     LEN_W'(1), 1'b0);
          fresh = 1'b1;
        end
      end
      MODE_BANG: begin
        mode_mid = MODE_IDLE;
        if (b == "=") begin
          va = 1'b1;
          ra = mk(KIND_NE, start_r, LEN_W'(2), 1'b0);
        end else begin
          fresh = 1'b1;
        end
      end
      MODE_ERR: begin
        // drop everything until the end of the statement
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // Start something new with this byte
    if (fresh) begin
      start_mid = p;
      mode_mid  = MODE_IDLE;
      if (!(is_space || b == ";")) begin
        if (is_alpha || b == "_") begin
          mode_mid        = MODE_WORD;
          word_buf_nxt[0] = b;
          len_mid         = LEN_W'(1);
        end else if (is_digit) begin
          mode_mid = MODE_NUM;
          len_mid  = LEN_W'(1);
        end else begin
          vb = 1'b1;
          case (b)
            "'": begin
              vb       = 1'b0;
              mode_mid = MODE_STR;
              len_mid  = LEN_W'(1);
            end
            "<": begin
              vb       = 1'b0;
              mode_mid = MODE_LT;
            end
            ">": begin
              vb       = 1'b0;
              mode_mid = MODE_GT;
            end
            "!": begin
              vb       = 1'b0;
              mode_mid = MODE_BANG;
            end
            ",":     rb = mk(KIND_COMMA,  p, LEN_W'(1), 1'b0);
            "(":     rb = mk(KIND_LPAREN, p, LEN_W'(1), 1'b0);
            ")":     rb = mk(KIND_RPAREN, p, LEN_W'(1), 1'b0);
            "=":     rb = mk(KIND_EQ,     p, LEN_W'(1), 1'b0);
            "+":     rb = mk(KIND_PLUS,   p, LEN_W'(1), 1'b0);
            "-":     rb = mk(KIND_MINUS,  p, LEN_W'(1), 1'b0);
            "*":     rb = mk(KIND_STAR,   p, LEN_W'(1), 1'b0);
            "/":     rb = mk(KIND_SLASH,  p, LEN_W'(1), 1'b0);
            ".":     rb = mk(KIND_IDENT,  p, LEN_W'(1), 1'b0);
            default: begin
              mode_mid = MODE_ERR;
              rb       = mk(KIND_END, p, LEN_W'(1), 1'b1);
            end
          endcase
        end
      end
    end

    for (int i = 0; i < KW_MAX; i++) begin
      txt_new[8*(KW_MAX-1-i) +: 8] = word_buf_nxt[i];
    end

    mode_nxt  = mode_mid;
    start_nxt = start_mid;
    len_nxt   = len_mid;
    pos_nxt   = sat_inc(pos_r);

    // End of statement: flush the pending token, report END, clear state
    if (last) begin
      vc = 1'b1;
      case (mode_mid)
        MODE_STR:  rc = mk(KIND_STRING, start_mid, len_mid, 1'b0);
        MODE_WORD: rc = mk(kw_kind(txt_new, kw_len(len_mid)), start_mid, len_mid, 1'b0);
        MODE_NUM:  rc = mk(KIND_NUMBER, start_mid, len_mid, 1'b0);
        MODE_LT:   rc = mk(KIND_LT, start_mid, LEN_W'(1), 1'b0);
        MODE_GT:   rc = mk(KIND_GT, start_mid, LEN_W'(1), 1'b0);
        default:   vc = 1'b0;
      endcase
      vd        = 1'b1;
      rd        = mk(KIND_END, '0, '0, mode_mid == MODE_ERR);
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      len_nxt   = '0;
      pos_nxt   = '0;
    end

    // Pack results in order and flag the last one of this beat
    push_c.valid   = {vd, vb | vc, va};
    push_c.slot[0] = ra;
    push_c.slot[1] = vb ? rb : rc;
    push_c.slot[2] = rd;
    if (vd) begin
      push_c.slot[2].run_last = 1'b1;
    end else if (vb | vc) begin
      push_c.slot[1].run_last = 1'b1;
    end else begin
      push_c.slot[0].run_last = va;
    end
    push = push_c;
  end

endmodule

/* sv/stl_res_fifo.sv */
// Result queue of the SQL token lexer: takes up to three results a cycle
// in order and hands out one result beat at a time. Uses stl_pkg.
module stl_res_fifo
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_data
);

  localparam int CNT_W = FIFO_PTR_W + 1;

  res_t                  mem_r [RES_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [FIFO_PTR_W-1:0] idx1, idx2;
  logic [CNT_W-1:0]      push_n;
  logic                  pop;

  // Place each valid result right after the previous valid one
  always_comb begin
    idx1   = wr_ptr_r + FIFO_PTR_W'(push.valid[0]);
    idx2   = idx1 + FIFO_PTR_W'(push.valid[1]);
    push_n = CNT_W'(push.valid[0]) + CNT_W'(push.valid[1]) + CNT_W'(push.valid[2]);
    pop    = out_valid && out_ready;
  end

  assign room      = cnt_r <= CNT_W'(RES_FIFO_DEPTH - MAX_RESULTS);
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_ptr_r];

  // Write results
  always_ff @(posedge clk) begin
    if (push.valid[0]) begin
      mem_r[wr_ptr_r] <= push.slot[0];
    end
    if (push.valid[1]) begin
      mem_r[idx1] <= push.slot[1];
    end
    if (push.valid[2]) begin
      mem_r[idx2] <= push.slot[2];
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[FIFO_PTR_W-1:0];
      rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(pop);
      cnt_r    <= cnt_r + push_n - CNT_W'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RES_FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid != '0) |-> room)
    else $error("results pushed without room for a full beat");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.valid == '0) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("result queue count not reduced by a lone pop");

endmodule

/* sv/sql_token_lexer.sv */
// Top level of the SQL token lexer: input register, scan state machine
// and result queue. Uses stl_pkg, stl_scan and stl_res_fifo.
//
// The lexer takes one statement byte per beat and returns tokens (kind,
// start offset, length, error flag, last-of-beat flag) in statement order.
// Bytes are accepted at one per cycle while the eight-entry result queue
// has room for the three results a byte can cause. Each byte waits in
// the input register until the queue has room; its results then go to
// the queue, which hands out one per cycle while out_ready is high, so
// a byte run that yields more than one token per byte is paced by the
// output port. No clearing pass is needed after reset.
module sql_token_lexer
  import stl_pkg::*;
#(
  parameter int MAX_STMT_BYTES = MAX_STMT_BYTES_DEF,
  parameter int KEYWORD_CHARS  = KEYWORD_CHARS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_data
);

  logic      stage_v_r;
  in_beat_t  stage_r;
  logic      fire, room;
  res_push_t push_raw, push_g;

  // Consume the held beat when the queue can take all of its results
  assign fire     = stage_v_r && room;
  assign in_ready = !stage_v_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_v_r <= 1'b1;
    end else if (fire) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= in_data;
    end
  end

  stl_scan #(
    .MAX_STMT_BYTES (MAX_STMT_BYTES),
    .KEYWORD_CHARS  (KEYWORD_CHARS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .beat  (stage_r),
    .push  (push_raw)
  );

  // Push results only for a consumed beat
  always_comb begin
    push_g       = push_raw;
    push_g.valid = push_raw.valid & {MAX_RESULTS{fire}};
  end

  stl_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_g),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
